### design/pvgt_pkg.sv
// ----------------------------------------------------------------------------
// pvgt_pkg - shared types and constants of the planar velocity goal tracker
// Field widths, register indexes, iteration counts and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pvgt_pkg;

  localparam int unsigned POS_W   = 16;  // position fields and goals
  localparam int unsigned SPD_W   = 23;  // max_speed and max_step
  localparam int unsigned GAIN_W  = 24;  // proportional gain
  localparam int unsigned VEL_W   = 24;  // held velocity, signed Q8
  localparam int unsigned MAG_W   = 25;  // raw velocity magnitude
  localparam int unsigned PROD_W  = 2 * MAG_W;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 24;
  localparam int unsigned CNT_W   = 5;

  // Iterations of the serial units, one bit or one root digit per cycle.
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SPD_W - 1);

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_GOAL_X    = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_GOAL_Y    = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_SPEED = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_MARGIN    = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_GAIN      = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_MAX_STEP  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULX,
    ST_MULY,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_SCX,
    ST_DVX,
    ST_SCY,
    ST_DVY,
    ST_SLEW,
    ST_DONE
  } pvgt_state_t;

endpackage

`default_nettype wire

### design/planar_velocity_goal_tracker.sv
// ----------------------------------------------------------------------------
// planar_velocity_goal_tracker - proportional position controller, slew limit
// Turns one measured x,y position into a slew-limited Q8 velocity command.
// ----------------------------------------------------------------------------
// Usage. Each input word on in_* carries one measured position. The block
// compares it with the configured goal, raises the per-axis reached flags,
// forms a proportional velocity, limits it to max_speed (per axis, or by
// vector magnitude when both axes are still moving) and moves the held
// velocity toward that command by at most max_step. One result word per
// input word leaves on out_*.
// All arithmetic runs through one shift-add multiplier, a digit-by-digit
// square root and a restoring divider, driven by one sequencer. Words with
// a single axis or no axis active, or a zero max_speed, take the x and y
// products only; with both axes active the squares and the square root
// follow, and a vector above max_speed is then scaled down by a product and
// a divide per axis. One item is in work at a time.
// Reset (rst_n low, synchronous) clears the configuration registers, state,
// output valid and held velocities. A stalled receiver only holds the last
// result in the output register; the next word is still taken and worked,
// and waits before that register. Registers are to be written through
// cfg_we/cfg_addr/cfg_wdata only while idle; the user must keep to this,
// as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_velocity_goal_tracker
  import pvgt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CFG_A_W-1:0]  cfg_addr,
  input  wire logic [CFG_D_W-1:0]  cfg_wdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [31:0]         in_tdata,   // pose_x[15:0], pose_y[31:16]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // vel_x[23:0], vel_y[47:24], x_reached[48], y_reached[49], zero pad above
  output logic [55:0]              out_tdata
);

  // Configuration registers.
  logic signed [POS_W-1:0] goal_x_r, goal_y_r;
  logic [SPD_W-1:0]        max_speed_r, max_step_r;
  logic [POS_W-1:0]        margin_r;
  logic [GAIN_W-1:0]       gain_r;

  pvgt_state_t state_r, state_nxt;

  // Item state.
  logic                sx_r, sy_r, xr_r, yr_r;
  logic [POS_W-1:0]    aym_r;
  logic [MAG_W-1:0]    vxm_r, vym_r;
  logic [SPD_W-1:0]    cmx_r, cmy_r;
  logic signed [VEL_W-1:0] held_x_r, held_y_r;

  // Shared serial units.
  logic [MAG_W-1:0]    mc_r, mp_r;
  logic [PROD_W-1:0]   acc_r, sum_r, rad_r;
  logic [MAG_W+1:0]    rem_r;
  logic [MAG_W-1:0]    root_r, drem_r;
  logic [SPD_W-1:0]    q_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  logic [55:0]         out_data_r;

  logic accept;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Error and reached flags of the incoming word.
  logic signed [POS_W:0] ex, ey, ax17, ay17;
  logic                  xr_in, yr_in;
  always_comb begin
    ex    = {goal_x_r[POS_W-1], goal_x_r} - {in_tdata[15], in_tdata[15:0]};
    ey    = {goal_y_r[POS_W-1], goal_y_r} - {in_tdata[31], in_tdata[31:16]};
    ax17  = ex[POS_W] ? -ex : ex;
    ay17  = ey[POS_W] ? -ey : ey;
    xr_in = ax17 < $signed({1'b0, margin_r});
    yr_in = ay17 < $signed({1'b0, margin_r});
  end

  // Multiplier step: MSB-first shift and add.
  logic [PROD_W-1:0] mul_sum;
  assign mul_sum = {acc_r[PROD_W-2:0], 1'b0} +
                   (mp_r[MAG_W-1] ? {{MAG_W{1'b0}}, mc_r} : '0);

  // Arithmetic shift by 16 of the signed product, seen as a magnitude:
  // a negative product rounds its magnitude up.
  logic        rnd_neg;
  logic [40:0] rnd_sum;
  logic [MAG_W-1:0] vmag;
  assign rnd_neg = (state_r == ST_MULX) ? sx_r : sy_r;
  assign rnd_sum = mul_sum[40:0] + (rnd_neg ? 41'd65535 : 41'd0);
  assign vmag    = rnd_sum[40:16];

  // Square root digit step.
  logic [MAG_W+1:0] remsh, trial;
  logic             sq_ge;
  logic [MAG_W-1:0] root_fin;
  assign remsh    = {rem_r[MAG_W-1:0], rad_r[PROD_W-1:PROD_W-2]};
  assign trial    = {root_r, 2'b01};
  assign sq_ge    = remsh >= trial;
  assign root_fin = {root_r[MAG_W-2:0], sq_ge};

  // Divider step: quotient bits come only from the low SPD_W bits of the
  // product, since the quotient never reaches 2^SPD_W.
  logic [MAG_W:0]  dt, dsub;
  logic            d_ge;
  logic [SPD_W-1:0] q_fin;
  assign dt    = {drem_r, acc_r[SPD_W-1]};
  assign dsub  = dt - {1'b0, root_r};
  assign d_ge  = dt >= {1'b0, root_r};
  assign q_fin = {q_r[SPD_W-2:0], d_ge};

  // Slew toward the command.
  logic signed [VEL_W+1:0] cmdx, cmdy, hix, lox, hiy, loy, newx, newy;
  always_comb begin
    cmdx = sx_r ? -$signed({3'b0, cmx_r}) : $signed({3'b0, cmx_r});
    cmdy = sy_r ? -$signed({3'b0, cmy_r}) : $signed({3'b0, cmy_r});
    hix  = {{2{held_x_r[VEL_W-1]}}, held_x_r} + $signed({3'b0, max_step_r});
    lox  = {{2{held_x_r[VEL_W-1]}}, held_x_r} - $signed({3'b0, max_step_r});
    hiy  = {{2{held_y_r[VEL_W-1]}}, held_y_r} + $signed({3'b0, max_step_r});
    loy  = {{2{held_y_r[VEL_W-1]}}, held_y_r} - $signed({3'b0, max_step_r});
    if (cmdx > hix) newx = hix;
    else if (cmdx < lox) newx = lox;
    else newx = cmdx;
    if (cmdy > hiy) newy = hiy;
    else if (cmdy < loy) newy = loy;
    else newy = cmdy;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  logic ms_zero;
  assign ms_zero = (max_speed_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MULX;
      ST_MULX: if (cnt_r == MUL_LAST) state_nxt = ST_MULY;
      ST_MULY: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = (ms_zero || xr_r || yr_r) ? ST_SLEW : ST_SQX;
        end
      end
      ST_SQX: if (cnt_r == MUL_LAST) state_nxt = ST_SQY;
      ST_SQY: if (cnt_r == MUL_LAST) state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = (root_fin > {2'b0, max_speed_r}) ? ST_SCX : ST_SLEW;
        end
      end
      ST_SCX: if (cnt_r == MUL_LAST) state_nxt = ST_DVX;
      ST_DVX: if (cnt_r == DIV_LAST) state_nxt = ST_SCY;
      ST_SCY: if (cnt_r == MUL_LAST) state_nxt = ST_DVY;
      ST_DVY: if (cnt_r == DIV_LAST) state_nxt = ST_SLEW;
      ST_SLEW: state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      max_speed_r <= '0;
      margin_r    <= '0;
      gain_r      <= '0;
      max_step_r  <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_GOAL_X:    goal_x_r    <= cfg_wdata[POS_W-1:0];
          REG_GOAL_Y:    goal_y_r    <= cfg_wdata[POS_W-1:0];
          REG_MAX_SPEED: max_speed_r <= cfg_wdata[SPD_W-1:0];
          REG_MARGIN:    margin_r    <= cfg_wdata[POS_W-1:0];
          REG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
          REG_MAX_STEP:  max_step_r  <= cfg_wdata[SPD_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_SLEW) begin
        held_x_r <= newx[VEL_W-1:0];
        held_y_r <= newy[VEL_W-1:0];
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_r + 1'b1;
    case (state_r)
      ST_IDLE: begin
        sx_r  <= ex[POS_W];
        sy_r  <= ey[POS_W];
        xr_r  <= xr_in;
        yr_r  <= yr_in;
        aym_r <= ay17[POS_W-1:0];
        mc_r  <= {1'b0, gain_r};
        mp_r  <= {9'b0, ax17[POS_W-1:0]};
        acc_r <= '0;
        cnt_r <= '0;
      end
      ST_MULX, ST_MULY, ST_SQX, ST_SQY, ST_SCX, ST_SCY: begin
        acc_r <= mul_sum;
        mp_r  <= {mp_r[MAG_W-2:0], 1'b0};
        if (cnt_r == MUL_LAST) begin
          cnt_r <= '0;
          acc_r <= '0;
          case (state_r)
            ST_MULX: begin
              vxm_r <= vmag;
              mc_r  <= {1'b0, gain_r};
              mp_r  <= {9'b0, aym_r};
            end
            ST_MULY: begin
              vym_r <= vmag;
              cmx_r <= '0;
              cmy_r <= '0;
              if (!ms_zero && !xr_r && yr_r) begin
                cmx_r <= (vxm_r > {2'b0, max_speed_r}) ? max_speed_r
                                                       : vxm_r[SPD_W-1:0];
              end else if (!ms_zero && xr_r && !yr_r) begin
                cmy_r <= (vmag > {2'b0, max_speed_r}) ? max_speed_r
                                                      : vmag[SPD_W-1:0];
              end
              mc_r <= vxm_r;
              mp_r <= vxm_r;
            end
            ST_SQX: begin
              sum_r <= mul_sum;
              mc_r  <= vym_r;
              mp_r  <= vym_r;
            end
            ST_SQY: begin
              rad_r  <= sum_r + mul_sum;
              rem_r  <= '0;
              root_r <= '0;
            end
            default: begin
              // Scaling product done: start the divide by the magnitude.
              acc_r  <= mul_sum;
              drem_r <= mul_sum[PROD_W-3:SPD_W];
            end
          endcase
        end
      end
      ST_SQRT: begin
        rad_r  <= {rad_r[PROD_W-3:0], 2'b00};
        rem_r  <= sq_ge ? (remsh - trial) : remsh;
        root_r <= root_fin;
        if (cnt_r == SQRT_LAST) begin
          cnt_r <= '0;
          acc_r <= '0;
          cmx_r <= vxm_r[SPD_W-1:0];
          cmy_r <= vym_r[SPD_W-1:0];
          mc_r  <= {2'b0, max_speed_r};
          mp_r  <= vxm_r;
        end
      end
      ST_DVX, ST_DVY: begin
        drem_r <= d_ge ? dsub[MAG_W-1:0] : dt[MAG_W-1:0];
        q_r    <= q_fin;
        acc_r  <= {acc_r[PROD_W-2:0], 1'b0};
        if (cnt_r == DIV_LAST) begin
          cnt_r <= '0;
          acc_r <= '0;
          if (state_r == ST_DVX) cmx_r <= q_fin;
          else cmy_r <= q_fin;
          mc_r <= {2'b0, max_speed_r};
          mp_r <= vym_r;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {6'b0, yr_r, xr_r, held_y_r, held_x_r};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/pvgt_checker.sv
// ----------------------------------------------------------------------------
// pvgt_checker - port-level checks of the goal tracker
// Watches the stream ports over time and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module pvgt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  // A result word that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // One word in work at a time: the input closes after a word is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted word");

  // A result cannot appear in the cycle right after its word is taken.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

endmodule

bind planar_velocity_goal_tracker pvgt_checker u_pvgt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
